[design/lpdc_pkg.sv]
package lpdc_pkg;

  localparam int POS_W   = 24;
  localparam int ERR_W   = 25;
  localparam int SPAN_W  = 20;
  localparam int HOLD_W  = 7;
  localparam int PWR_W   = 8;
  localparam int MODE_W  = 3;
  localparam int IDX_W   = 3;
  localparam int PROD_W  = 28;
  localparam int NUM_W   = 29;
  localparam int DVD_W   = 30;
  localparam int DVS_W   = 21;
  localparam int QUO_W   = 8;
  localparam int STEP_W  = 3;
  localparam int DSH_W   = DVS_W + QUO_W - 1;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

  localparam logic [PWR_W-1:0] PWR_MAX = 8'sd127;
  localparam logic [PWR_W-1:0] PWR_MIN = -8'sd127;
  localparam logic [PWR_W-1:0] PWR_NEG_FULL = 8'h80;

  localparam logic [MODE_W-1:0] MODE_INVALID   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MANUAL    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_AT_LIMIT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HOLD_OFF  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PROFILE   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_KICK      = 3'd5;

  localparam logic [IDX_W-1:0] REG_HOLD_EN   = 3'd0;
  localparam logic [IDX_W-1:0] REG_LOWER     = 3'd1;
  localparam logic [IDX_W-1:0] REG_UPPER     = 3'd2;
  localparam logic [IDX_W-1:0] REG_HOLD_PWR  = 3'd3;
  localparam logic [IDX_W-1:0] REG_SLOWDOWN  = 3'd4;
  localparam logic [IDX_W-1:0] REG_KICK      = 3'd5;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[design/lpdc_div.sv]
module lpdc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [lpdc_pkg::DVD_W-1:0]        dividend,
  input  logic [lpdc_pkg::DVS_W-1:0]        divisor,
  output logic [lpdc_pkg::QUO_W-1:0]        quotient,
  output lpdc_pkg::div_status_t             status
);

  logic [lpdc_pkg::DVD_W-1:0]  rem;
  logic [lpdc_pkg::DSH_W-1:0]  dsh;
  logic [lpdc_pkg::STEP_W-1:0] step;
  logic                        busy;
  logic                        done;
  logic [lpdc_pkg::DVD_W-1:0]  dsh_ext;
  logic                        fits;

  assign dsh_ext = {{(lpdc_pkg::DVD_W-lpdc_pkg::DSH_W){1'b0}}, dsh};
  assign fits    = rem >= dsh_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == lpdc_pkg::LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= {divisor, {(lpdc_pkg::QUO_W-1){1'b0}}};
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh_ext;
      end
      quotient <= {quotient[lpdc_pkg::QUO_W-2:0], fits};
      dsh      <= dsh >> 1;
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

[design/lift_position_drive_controller.sv]
// channel | signals                                               | transfer when
// in      | position_cdeg position_valid manual_power target_cdeg | in_valid & in_ready
// out     | motor_power drive_mode                                | out_valid & out_ready
// cfg     | cfg_write cfg_index cfg_data                          | cfg_write
//
// decided items pass S_DECIDE on the way to the result register; profile items inside
// the slowdown span also pass the 8-step shift-subtract divider behind one shared multiplier
// in_ready is high only while the sequencer is idle; a new item may enter while
// the last result still waits on out_ready
// rst is synchronous, active high, restores register defaults and clears tracking
module lift_position_drive_controller (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [lpdc_pkg::POS_W-1:0]      position_cdeg,
  input  logic                                   position_valid,
  input  logic signed [lpdc_pkg::PWR_W-1:0]      manual_power,
  input  logic signed [lpdc_pkg::POS_W-1:0]      target_cdeg,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [lpdc_pkg::PWR_W-1:0]      motor_power,
  output logic [lpdc_pkg::MODE_W-1:0]            drive_mode,
  input  logic                                   cfg_write,
  input  logic [lpdc_pkg::IDX_W-1:0]             cfg_index,
  input  logic [lpdc_pkg::POS_W-1:0]             cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_MUL_A  = 3'd2;
  localparam logic [2:0] S_MUL_B  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_WAIT   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state;

  logic                               hold_enabled;
  logic signed [lpdc_pkg::POS_W-1:0]  lower_limit_cdeg;
  logic signed [lpdc_pkg::POS_W-1:0]  upper_limit_cdeg;
  logic [lpdc_pkg::HOLD_W-1:0]        hold_power;
  logic [lpdc_pkg::SPAN_W-1:0]        slowdown_cdeg;
  logic [lpdc_pkg::SPAN_W-1:0]        kick_threshold_cdeg;

  logic signed [lpdc_pkg::POS_W-1:0]  last_target;
  logic                               tracking_active;

  logic signed [lpdc_pkg::POS_W-1:0]  pos;
  logic signed [lpdc_pkg::POS_W-1:0]  target;
  logic signed [lpdc_pkg::PWR_W-1:0]  manual;
  logic                               valid;

  logic                               e_neg;
  logic [lpdc_pkg::SPAN_W-1:0]        mag_lo;
  logic [lpdc_pkg::HOLD_W-1:0]        h_reg;
  logic [lpdc_pkg::SPAN_W-1:0]        s_reg;
  logic [lpdc_pkg::PROD_W-1:0]        acc;
  logic [lpdc_pkg::NUM_W-1:0]         num_mag;
  logic                               num_neg;
  logic [lpdc_pkg::PWR_W-1:0]         power_res;
  logic [lpdc_pkg::MODE_W-1:0]        mode_res;

  logic signed [lpdc_pkg::ERR_W-1:0]  err;
  logic [lpdc_pkg::ERR_W-1:0]         mag;
  logic [lpdc_pkg::SPAN_W-1:0]        s_eff;
  logic                               changed;
  logic                               at_upper;
  logic                               at_lower;

  logic [lpdc_pkg::PWR_W-1:0]         mul_a;
  logic [lpdc_pkg::SPAN_W-1:0]        mul_b;
  logic [lpdc_pkg::PROD_W-1:0]        prod;

  logic                               div_start;
  logic [lpdc_pkg::DVD_W-1:0]         div_dividend;
  logic [lpdc_pkg::DVS_W-1:0]         div_divisor;
  logic [lpdc_pkg::QUO_W-1:0]         quotient;
  lpdc_pkg::div_status_t              div_status;
  logic [lpdc_pkg::QUO_W-1:0]         q_sat;
  logic                               load_out;

  assign in_ready = (state == S_IDLE) && !rst;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  assign err   = {target[lpdc_pkg::POS_W-1], target} - {pos[lpdc_pkg::POS_W-1], pos};
  assign mag   = err[lpdc_pkg::ERR_W-1] ? lpdc_pkg::ERR_W'(-err) : lpdc_pkg::ERR_W'(err);
  assign s_eff = (slowdown_cdeg == '0) ? lpdc_pkg::SPAN_W'(1) : slowdown_cdeg;
  assign changed  = !tracking_active || (target != last_target);
  assign at_upper = (manual > 0) && (pos >= upper_limit_cdeg);
  assign at_lower = (manual < 0) && (pos <= lower_limit_cdeg);

  // one multiplier shared by both product terms
  always_comb begin
    if (state == S_MUL_A) begin
      mul_a = {1'b0, h_reg};
      mul_b = s_reg;
    end else begin
      mul_a = e_neg ? (lpdc_pkg::PWR_MAX + {1'b0, h_reg}) : (lpdc_pkg::PWR_MAX - {1'b0, h_reg});
      mul_b = mag_lo;
    end
  end
  assign prod = {{(lpdc_pkg::PROD_W-lpdc_pkg::PWR_W){1'b0}}, mul_a}
              * {{(lpdc_pkg::PROD_W-lpdc_pkg::SPAN_W){1'b0}}, mul_b};

  assign div_start    = (state == S_DIV);
  assign div_dividend = {num_mag, 1'b0}
                      + {{(lpdc_pkg::DVD_W-lpdc_pkg::SPAN_W){1'b0}}, s_reg};
  assign div_divisor  = {s_reg, 1'b0};
  assign q_sat = (quotient > lpdc_pkg::PWR_MAX) ? lpdc_pkg::PWR_MAX : quotient;

  lpdc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .status   (div_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_enabled        <= 1'b1;
      lower_limit_cdeg    <= '0;
      upper_limit_cdeg    <= 24'sd36000;
      hold_power          <= 7'd25;
      slowdown_cdeg       <= 20'd15000;
      kick_threshold_cdeg <= 20'd100;
    end else if (cfg_write) begin
      case (cfg_index)
        lpdc_pkg::REG_HOLD_EN:  hold_enabled        <= cfg_data[0];
        lpdc_pkg::REG_LOWER:    lower_limit_cdeg    <= cfg_data;
        lpdc_pkg::REG_UPPER:    upper_limit_cdeg    <= cfg_data;
        lpdc_pkg::REG_HOLD_PWR: hold_power          <= cfg_data[lpdc_pkg::HOLD_W-1:0];
        lpdc_pkg::REG_SLOWDOWN: slowdown_cdeg       <= cfg_data[lpdc_pkg::SPAN_W-1:0];
        lpdc_pkg::REG_KICK:     kick_threshold_cdeg <= cfg_data[lpdc_pkg::SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      tracking_active <= 1'b0;
      last_target     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && out_ready && !load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= S_DONE;
          if (!valid || manual != 0 || !hold_enabled) begin
            tracking_active <= 1'b0;
          end else begin
            if (changed) begin
              last_target     <= target;
              tracking_active <= 1'b1;
            end
            if (!(changed && mag > {5'b0, kick_threshold_cdeg})
                && mag < {5'b0, s_eff}) begin
              state <= S_MUL_A;
            end
          end
        end
        S_MUL_A: state <= S_MUL_B;
        S_MUL_B: state <= S_DIV;
        S_DIV:   state <= S_WAIT;
        S_WAIT: begin
          if (div_status.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pos    <= position_cdeg;
      target <= target_cdeg;
      manual <= manual_power;
      valid  <= position_valid;
    end
    if (load_out) begin
      motor_power <= power_res;
      drive_mode  <= mode_res;
    end
    case (state)
      S_DECIDE: begin
        e_neg  <= err[lpdc_pkg::ERR_W-1];
        mag_lo <= mag[lpdc_pkg::SPAN_W-1:0];
        h_reg  <= (target > 0) ? hold_power : '0;
        s_reg  <= s_eff;
        power_res <= '0;
        if (!valid) begin
          mode_res <= lpdc_pkg::MODE_INVALID;
        end else if (manual != 0) begin
          if (at_upper || at_lower) begin
            mode_res <= lpdc_pkg::MODE_AT_LIMIT;
          end else begin
            mode_res  <= lpdc_pkg::MODE_MANUAL;
            power_res <= (manual == lpdc_pkg::PWR_NEG_FULL) ? lpdc_pkg::PWR_MIN : manual;
          end
        end else if (!hold_enabled) begin
          mode_res <= lpdc_pkg::MODE_HOLD_OFF;
        end else if (changed && mag > {5'b0, kick_threshold_cdeg}) begin
          mode_res  <= lpdc_pkg::MODE_KICK;
          power_res <= err[lpdc_pkg::ERR_W-1] ? lpdc_pkg::PWR_MIN : lpdc_pkg::PWR_MAX;
        end else begin
          mode_res  <= lpdc_pkg::MODE_PROFILE;
          power_res <= err[lpdc_pkg::ERR_W-1] ? lpdc_pkg::PWR_MIN : lpdc_pkg::PWR_MAX;
        end
      end
      S_MUL_A: acc <= prod;
      S_MUL_B: begin
        if (!e_neg) begin
          num_mag <= {1'b0, acc} + {1'b0, prod};
          num_neg <= 1'b0;
        end else if (acc >= prod) begin
          num_mag <= {1'b0, acc - prod};
          num_neg <= 1'b0;
        end else begin
          num_mag <= {1'b0, prod - acc};
          num_neg <= 1'b1;
        end
      end
      S_WAIT: begin
        if (div_status.done) begin
          power_res <= num_neg ? lpdc_pkg::PWR_W'(-q_sat) : q_sat;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_div_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> state == S_WAIT)
    else $error("divider finished outside the wait state");

  a_no_full_negative: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> motor_power != lpdc_pkg::PWR_NEG_FULL)
    else $error("motor power out of range");

  a_kick_full_power: assert property (@(posedge clk) disable iff (rst)
    (out_valid && drive_mode == lpdc_pkg::MODE_KICK)
      |-> (motor_power == lpdc_pkg::PWR_MAX || motor_power == lpdc_pkg::PWR_MIN))
    else $error("kick without full power");

  a_zero_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (drive_mode == lpdc_pkg::MODE_INVALID
      || drive_mode == lpdc_pkg::MODE_AT_LIMIT || drive_mode == lpdc_pkg::MODE_HOLD_OFF))
      |-> motor_power == '0)
    else $error("nonzero power in a blocked mode");

  a_tracking_after_kick: assert property (@(posedge clk) disable iff (rst)
    load_out && mode_res == lpdc_pkg::MODE_KICK |-> tracking_active)
    else $error("kick issued without a latched target");
`endif

endmodule
